/* hdl/rlq_pkg.sv */
// Shared types, constants and the float conversion table for the RGB layout quantiser.
`default_nettype none
package rlq_pkg;

	localparam int MAX_PLANE = 1048576;
	localparam int PIX_W     = $clog2(MAX_PLANE);
	localparam int PLANE_W   = 21;
	localparam int IDX_W     = 22;
	localparam int VAL_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int MULT_W    = 32;
	localparam int PROD_W    = BYTE_W + MULT_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_PLANAR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INT8_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUANT_MULT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUANT_OFS  = 3'd4;

	localparam logic [1:0] LAST_CHANNEL = 2'd2;

	typedef struct packed {
		logic                     planar_layout;
		logic                     int8_mode;
		logic [PLANE_W-1:0]       plane_size;
		logic [MULT_W-1:0]        quant_multiplier;
		logic signed [BYTE_W-1:0] quant_offset;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] pixel_byte;
		logic [IDX_W-1:0]  dest_index;
		logic              image_done;
	} entry_t;

	typedef logic [VAL_W-1:0] lut_t [256];

	// Single precision bits of b/255, rounded to nearest; b/255 is never a tie.
	function automatic lut_t build_float_lut();
		lut_t        lut;
		logic [63:0] num;
		logic [63:0] m;
		logic [63:0] r;
		int          k;
		for (int b = 0; b < 256; b++) begin
			if (b == 0) begin
				lut[b] = '0;
			end else if (b == 255) begin
				lut[b] = 32'h3F80_0000;
			end else begin
				k = 1;
				for (int j = 0; j < 7; j++) begin
					if ((b << k) < 255) k = k + 1;
				end
				num = 64'(b) << (23 + k);
				m = num / 255;
				r = num % 255;
				if (2 * r > 255) m = m + 1;
				lut[b] = VAL_W'((64'(127 - k) << 23) + (m - (64'd1 << 23)));
			end
		end
		return lut;
	endfunction

	localparam lut_t FLOAT_LUT = build_float_lut();

endpackage
`default_nettype wire

/* hdl/rgb_layout_quantize_top.sv */
// Top level of the RGB layout quantiser: configuration registers, front end, queue and back end.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[31:0]
//  in      | in        | in_valid / in_ready    | pixel_byte[7:0]
//  out     | out       | out_valid / out_ready  | dest_index[21:0], out_value[31:0], image_done
//
// One word is taken per clock while the queue has room, and one result leaves per clock while
// out_ready is high; a word passes the queue write, the multiplier register and the output
// register before out_valid rises.
// in_ready falls only when the four-entry queue fills, which happens after out_ready has
// been held low long enough. Reset clears the counters, the queue and the pipeline valids,
// and returns the registers to their defaults; cfg_ready is always high.
`default_nettype none
module rgb_layout_quantize_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  pixel_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [21:0]      dest_index,
	output logic [31:0]      out_value,
	output logic             image_done
);
	import rlq_pkg::*;

	cfg_t   cfg_q;
	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   q_not_empty;
	logic   q_pop;
	entry_t q_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.planar_layout    <= 1'b0;
			cfg_q.int8_mode        <= 1'b1;
			cfg_q.plane_size       <= PLANE_W'(1);
			cfg_q.quant_multiplier <= MULT_W'(65536);
			cfg_q.quant_offset     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PLANAR:     cfg_q.planar_layout    <= cfg_data[0];
				REG_INT8_MODE:  cfg_q.int8_mode        <= cfg_data[0];
				REG_PLANE_SIZE: cfg_q.plane_size       <= cfg_data[PLANE_W-1:0];
				REG_QUANT_MULT: cfg_q.quant_multiplier <= cfg_data[MULT_W-1:0];
				REG_QUANT_OFS:  cfg_q.quant_offset     <= signed'(cfg_data[BYTE_W-1:0]);
				default: ;
			endcase
		end
	end

	rlq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_byte (pixel_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	rlq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.pop        (q_pop),
		.pop_entry  (q_entry)
	);

	rlq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_pop       (q_pop),
		.q_entry     (q_entry),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest_index  (dest_index),
		.out_value   (out_value),
		.image_done  (image_done)
	);

endmodule
`default_nettype wire

/* hdl/rlq_front.sv */
// Front end: accepts colour bytes, tracks pixel and channel, and works out index and image end.
`default_nettype none
module rlq_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rlq_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    pixel_byte,
	input  wire logic          q_full,
	output logic               push,
	output rlq_pkg::entry_t    push_entry
);
	import rlq_pkg::*;

	logic [PIX_W-1:0]   pixel_q;
	logic [1:0]         channel_q;
	logic [PLANE_W-1:0] plane_eff;
	logic [IDX_W-1:0]   chan_base;
	logic [IDX_W-1:0]   idx;
	logic               last_pixel;
	logic               done;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		if (cfg.plane_size == '0) begin
			plane_eff = PLANE_W'(1);
		end else if (cfg.plane_size > PLANE_W'(MAX_PLANE)) begin
			plane_eff = PLANE_W'(MAX_PLANE);
		end else begin
			plane_eff = cfg.plane_size;
		end
	end

	always_comb begin
		case (channel_q)
			2'd0:    chan_base = '0;
			2'd1:    chan_base = IDX_W'(plane_eff);
			default: chan_base = IDX_W'(plane_eff) << 1;
		endcase
		if (cfg.planar_layout) begin
			idx = chan_base + IDX_W'(pixel_q);
		end else begin
			idx = (IDX_W'(pixel_q) << 1) + IDX_W'(pixel_q) + IDX_W'(channel_q);
		end
	end

	// A plane shrunk below the current pixel also ends the image on its last channel.
	assign last_pixel = (PLANE_W'(pixel_q) + PLANE_W'(1)) >= plane_eff;
	assign done       = (channel_q >= LAST_CHANNEL) && last_pixel;

	assign push_entry.pixel_byte = pixel_byte;
	assign push_entry.dest_index = idx;
	assign push_entry.image_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q   <= '0;
			channel_q <= '0;
		end else if (push) begin
			if (channel_q >= LAST_CHANNEL) begin
				channel_q <= '0;
				pixel_q   <= last_pixel ? '0 : pixel_q + PIX_W'(1);
			end else begin
				channel_q <= channel_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/rlq_queue.sv */
// Short queue of classified words between the front end and the value pipeline.
`default_nettype none
module rlq_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rlq_pkg::entry_t push_entry,
	output logic                 full,
	output logic                 not_empty,
	input  wire logic            pop,
	output rlq_pkg::entry_t      pop_entry
);
	import rlq_pkg::*;

	entry_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == QCNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/rlq_back.sv */
// Back end: two-stage value pipeline with the int8 quantiser, float table and output register.
`default_nettype none
module rlq_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rlq_pkg::cfg_t   cfg,
	input  wire logic            q_not_empty,
	output logic                 q_pop,
	input  wire rlq_pkg::entry_t q_entry,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [21:0]          dest_index,
	output logic [31:0]          out_value,
	output logic                 image_done
);
	import rlq_pkg::*;

	localparam int SUM_W = PROD_W + 1;
	localparam int Q_W   = SUM_W - 16;
	localparam int S_W   = Q_W + 2;

	logic              valid_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              done_s1;
	logic              valid_s2;
	logic              adv_s1;
	logic              adv_s2;

	logic [SUM_W-1:0]  rounded;
	logic signed [S_W-1:0] shifted;
	logic signed [S_W-1:0] biased;
	logic [BYTE_W-1:0] clamped;
	logic [VAL_W-1:0]  value;

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign q_pop  = q_not_empty && adv_s1;

	always_comb begin
		rounded = SUM_W'(prod_s1) + SUM_W'(32768);
		shifted = signed'({2'b00, rounded[SUM_W-1:16]});
		biased  = shifted + S_W'(cfg.quant_offset);
		if (biased < -S_W'(128)) begin
			clamped = 8'h80;
		end else if (biased > S_W'(127)) begin
			clamped = 8'h7F;
		end else begin
			clamped = biased[BYTE_W-1:0];
		end
		if (cfg.int8_mode) begin
			value = {{(VAL_W - BYTE_W){clamped[BYTE_W-1]}}, clamped};
		end else begin
			value = FLOAT_LUT[byte_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= q_not_empty;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s1 <= PROD_W'(q_entry.pixel_byte) * PROD_W'(cfg.quant_multiplier);
			byte_s1 <= q_entry.pixel_byte;
			idx_s1  <= q_entry.dest_index;
			done_s1 <= q_entry.image_done;
		end
		if (adv_s2 && valid_s1) begin
			dest_index <= idx_s1;
			out_value  <= value;
			image_done <= done_s1;
		end
	end

	assign out_valid = valid_s2;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the RGB layout quantiser, with a clocked driver, monitor and predictor.
module tb_top;
	import rlq_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int IDLE_PCT     = 34;
	localparam int RANDOM_ITEMS = 450;
	localparam int STEADY_PHASE = 3;
	localparam int STEADY_ITEMS = 60;
	localparam longint Q_MIN    = -128;
	localparam longint Q_MAX    = 127;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [VAL_W-1:0]     FLOAT_ONE    = 32'h3F80_0000;

	typedef struct packed {
		logic [IDX_W-1:0] dest_index;
		logic [VAL_W-1:0] out_value;
		logic             image_done;
	} tensor_elem_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} reg_write_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DAT_W-1:0] cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    pixel_byte = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [IDX_W-1:0]     dest_index;
	logic [VAL_W-1:0]     out_value;
	logic                 image_done;

	// Copy of the block's registers and counters; the counters advance on each accepted word.
	logic                     m_planar  = 1'b0;
	logic                     m_int8    = 1'b1;
	logic [PLANE_W-1:0]       m_plane   = 21'd1;
	logic [MULT_W-1:0]        m_mult    = 32'd65536;
	logic signed [BYTE_W-1:0] m_offset  = '0;
	logic [PIX_W-1:0]         m_pixel   = '0;
	logic [1:0]               m_channel = '0;

	logic [BYTE_W-1:0] byte_stream[$];
	reg_write_t        reg_writes[$];
	tensor_elem_t      expected_elems[$];
	logic              steady = 1'b0;
	int                errors = 0;
	int                cycles = 0;

	rgb_layout_quantize_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_byte (pixel_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dest_index (dest_index),
		.out_value  (out_value),
		.image_done (image_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Single precision bits of b/255 with round to nearest, worked out in integers.
	function automatic logic [VAL_W-1:0] unit_float_bits(input logic [BYTE_W-1:0] b);
		int unsigned shift;
		logic [63:0] scaled;
		logic [63:0] mant;
		logic [63:0] rem;
		if (b == 0)
			return '0;
		if (b == 8'hFF)
			return FLOAT_ONE;
		shift = 1;
		while ((32'(b) << shift) < 255)
			shift++;
		scaled = 64'(b) << (23 + shift);
		mant   = scaled / 255;
		rem    = scaled % 255;
		if (2 * rem > 255)
			mant++;
		return VAL_W'((64'(127 - shift) << 23) + (mant - (64'd1 << 23)));
	endfunction

	task automatic predict_elem(input logic [BYTE_W-1:0] b);
		tensor_elem_t e;
		int unsigned  plane;
		logic [63:0]  prod;
		longint       q;
		plane = 32'(m_plane);
		if (plane == 0)
			plane = 1;
		if (plane > MAX_PLANE)
			plane = MAX_PLANE;
		if (m_planar)
			e.dest_index = IDX_W'(32'(m_channel) * plane + 32'(m_pixel));
		else
			e.dest_index = IDX_W'(32'(m_pixel) * 3 + 32'(m_channel));
		if (m_int8) begin
			prod = 64'(b) * 64'(m_mult) + 64'd32768;
			q = longint'(prod >> 16) + longint'(m_offset);
			if (q < Q_MIN)
				q = Q_MIN;
			if (q > Q_MAX)
				q = Q_MAX;
			e.out_value = VAL_W'(q);
		end else begin
			e.out_value = unit_float_bits(b);
		end
		e.image_done = 1'b0;
		if (m_channel == LAST_CHANNEL) begin
			m_channel = '0;
			if (32'(m_pixel) + 1 >= plane) begin
				m_pixel = '0;
				e.image_done = 1'b1;
			end else begin
				m_pixel++;
			end
		end else begin
			m_channel++;
		end
		expected_elems.push_back(e);
	endtask

	// Byte driver: valid is held with its payload until the word is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_elem(pixel_byte);
			if (!in_valid || in_ready) begin
				if (byte_stream.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid   <= 1'b1;
					pixel_byte <= byte_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver; the shadow copy is updated when the write is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PLANAR:     m_planar = cfg_data[0];
					REG_INT8_MODE:  m_int8   = cfg_data[0];
					REG_PLANE_SIZE: m_plane  = cfg_data[PLANE_W-1:0];
					REG_QUANT_MULT: m_mult   = cfg_data[MULT_W-1:0];
					REG_QUANT_OFS:  m_offset = cfg_data[BYTE_W-1:0];
					default:        ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes.size() != 0) begin
					cfg_valid              <= 1'b1;
					{cfg_index, cfg_data} <= reg_writes.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		tensor_elem_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_elems.size() == 0) begin
					$error("unexpected word: dest_index %0d out_value %h", dest_index, out_value);
					errors++;
				end else begin
					want = expected_elems.pop_front();
					if (dest_index !== want.dest_index) begin
						$error("dest_index: expected %0d, got %0d", want.dest_index, dest_index);
						errors++;
					end
					if (out_value !== want.out_value) begin
						$error("out_value: expected %h, got %h", want.out_value, out_value);
						errors++;
					end
					if (image_done !== want.image_done) begin
						$error("image_done: expected %0d, got %0d", want.image_done, image_done);
						errors++;
					end
				end
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic quiesce();
		@(negedge clk);
		while (byte_stream.size() != 0 || in_valid || reg_writes.size() != 0 || cfg_valid
				|| expected_elems.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] data);
		reg_write_t w;
		w.index = index;
		w.data  = data;
		reg_writes.push_back(w);
	endtask

	task automatic push_bytes(input logic [BYTE_W-1:0] bytes[$]);
		foreach (bytes[i])
			byte_stream.push_back(bytes[i]);
	endtask

	initial begin
		int                sent;
		int                phase;
		int                n;
		logic [31:0]       v;
		logic [BYTE_W-1:0] b;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: int8 with unity multiplier, one pixel per image.
		quiesce();
		push_bytes('{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE});

		// Float output, interleaved, four pixels per image.
		quiesce();
		push_write(REG_PLANAR, 32'd0);
		push_write(REG_INT8_MODE, 32'd0);
		push_write(REG_PLANE_SIZE, 32'd4);
		quiesce();
		push_bytes('{8'h00, 8'h01, 8'h02, 8'h7F, 8'h80, 8'hFE, 8'hFF});

		// Planar with a zero plane size written mid-image, so the open pixel ends it.
		quiesce();
		push_write(REG_PLANAR, 32'd1);
		push_write(REG_PLANE_SIZE, 32'd0);
		quiesce();
		push_bytes('{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01});

		// Oversized plane, full-scale multiplier, lowest zero point and spare indexes.
		quiesce();
		push_write(REG_INT8_MODE, 32'd1);
		push_write(REG_PLANE_SIZE, 32'h001F_FFFF);
		push_write(REG_QUANT_MULT, 32'hFFFF_FFFF);
		push_write(REG_QUANT_OFS, 32'hFFFF_FF80);
		push_write(REG_SPARE_LO, 32'h0000_0001);
		push_write(REG_SPARE_HI, 32'hFFFF_FFFF);
		quiesce();
		push_bytes('{8'h00, 8'hFF, 8'h01});

		// Zero multiplier with the highest zero point gives the offset alone.
		quiesce();
		push_write(REG_QUANT_MULT, 32'd0);
		push_write(REG_QUANT_OFS, 32'd127);
		push_write(REG_PLANE_SIZE, 32'd2);
		quiesce();
		push_bytes('{8'hFF, 8'h00, 8'h80});

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			quiesce();
			steady = (phase == STEADY_PHASE);
			if ($urandom_range(1) == 0)
				push_write(REG_PLANAR, $urandom);
			if ($urandom_range(1) == 0)
				push_write(REG_INT8_MODE, $urandom);
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0:       v = 32'd0;
					1:       v = 32'h001F_FFFF;
					2:       v = MAX_PLANE;
					3:       v = $urandom;
					default: v = $urandom_range(1, 6);
				endcase
				push_write(REG_PLANE_SIZE, ($urandom & 32'hFFE0_0000) | (v & 32'h001F_FFFF));
			end
			if ($urandom_range(1) == 0) begin
				case ($urandom_range(7))
					0:       v = 32'd0;
					1:       v = 32'hFFFF_FFFF;
					2:       v = $urandom;
					default: v = $urandom_range(0, 32'h0003_0000);
				endcase
				push_write(REG_QUANT_MULT, v);
			end
			if ($urandom_range(2) == 0)
				push_write(REG_QUANT_OFS, $urandom);
			if ($urandom_range(7) == 0)
				push_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
			quiesce();
			n = steady ? STEADY_ITEMS : $urandom_range(8, 40);
			repeat (n) begin
				case ($urandom_range(9))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = BYTE_W'($urandom);
				endcase
				byte_stream.push_back(b);
			end
			sent += n;
			phase++;
		end

		quiesce();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
hdl/rlq_pkg.sv
hdl/rlq_front.sv
hdl/rlq_queue.sv
hdl/rlq_back.sv
hdl/rgb_layout_quantize_top.sv
sim/tb_top.sv
